[rtl/urs_pkg.sv]
`timescale 1ns / 1ps

package urs_pkg;

    // phase codes
    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_TRIG   = 2'd1;
    localparam logic [1:0] PH_LISTEN = 2'd2;
    localparam logic [1:0] PH_HIGH   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR      = 3'd5;

    localparam int unsigned CFG_DATA_W = 18;
    localparam int unsigned DIST_W     = 9;

    // reset values
    localparam logic [17:0]       RST_REPEAT   = 18'd150000;
    localparam logic [7:0]        RST_TRIGGER  = 8'd10;
    localparam logic [15:0]       RST_TIMEOUT  = 16'd25000;
    localparam logic [14:0]       RST_MAX_ECHO = 15'd25000;
    localparam logic [DIST_W-1:0] RST_NEAR     = 9'd25;
    localparam logic [DIST_W-1:0] RST_FAR      = 9'd400;
    localparam logic [DIST_W-1:0] RST_DIST     = 9'd400;

    // width*34/2000 = width*17/1000, done as (width * 17 * ceil(2^30/1000)) >> 30,
    // exact for every width below 2^15
    localparam int unsigned        DIV_SHIFT = 30;
    localparam logic [24:0]        DIV_MULT  = 25'd18253614;
    localparam logic [DIST_W:0]    DIST_MAX  = 10'd511;

    typedef struct packed {
        logic [17:0]       repeat_ticks;
        logic [7:0]        trigger_ticks;
        logic [15:0]       echo_timeout_ticks;
        logic [14:0]       max_echo_ticks;
        logic [DIST_W-1:0] near_cm;
        logic [DIST_W-1:0] far_cm;
    } cfg_t;

endpackage

[rtl/urs_distance.sv]
`timescale 1ns / 1ps

module urs_distance
    import urs_pkg::*;
(
    input  logic [15:0]       echo_width,
    input  cfg_t              cfg,
    output logic [DIST_W-1:0] distance
);

    logic [39:0]     prod;
    logic [DIST_W:0] quot;
    logic            too_long;

    assign too_long = (echo_width >= {1'b0, cfg.max_echo_ticks});
    // below max_echo_ticks the width fits in 15 bits
    assign prod     = {25'd0, echo_width[14:0]} * {15'd0, DIV_MULT};
    assign quot     = prod[DIV_SHIFT +: DIST_W + 1];

    always_comb
    begin
        if (too_long || (quot > DIST_MAX))
        begin
            distance = cfg.far_cm;
        end
        else
        begin
            distance = quot[DIST_W-1:0];
        end
    end

endmodule

[rtl/ultrasonic_range_sequencer.sv]
`timescale 1ns / 1ps

// ultrasonic range sequencer
// s_axis carries one transaction per microsecond tick; bit 0 of s_axis_tdata is the
// sampled echo pin level. every input transaction yields exactly one output transaction
// on m_axis with the trigger drive for that tick, the held distance in cm, an update
// strobe and the near flag.
// the sequence is: idle for repeat_ticks, drive trigger for trigger_ticks, wait for
// the echo rising edge, count the high width, store width*34/2000 cm on the falling edge.
// a missing or overlong echo returns to idle and keeps the old distance; a width of
// max_echo_ticks or more, or a result over 511 cm, stores far_cm. throughput: one
// transaction per cycle unless m_axis stalls; the tick counters, the echo edge detect and
// the distance multiplier all sit between the state registers and the output register.
// registers are written over the cfg channel (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce. reset puts the
// sequencer in the idle phase with counters cleared, distance 400 cm and all registers
// at their defaults. when m_axis stalls the output register holds; s_axis_tready stays
// high only while the output register is empty or being drained in the same cycle.
module ultrasonic_range_sequencer
    import urs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cfg write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] echo_level, [7:1] zero
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata    // [0] trigger_out, [9:1] distance_cm,
                                                  // [10] distance_updated, [11] near_flag,
                                                  // [15:12] zero
);

    cfg_t              cfg_reg;
    logic [1:0]        phase_reg, phase_next;
    logic [17:0]       phase_ticks_reg, phase_ticks_next;
    logic [15:0]       echo_width_reg, echo_width_next;
    logic              echo_prev_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              m_valid_reg;
    logic [15:0]       m_tdata_reg;

    logic              s_fire;
    logic              echo_level;
    logic              rise;
    logic              fall;
    logic              upd;
    logic              trig;
    logic [17:0]       ticks_inc;
    logic [DIST_W-1:0] dist_calc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    assign echo_level = s_axis_tdata[0];
    assign rise       = echo_level && !echo_prev_reg;
    assign fall       = !echo_level && echo_prev_reg;
    assign trig       = (phase_reg == PH_TRIG);
    assign ticks_inc  = phase_ticks_reg + 18'd1;

    urs_distance u_distance (
        .echo_width (echo_width_reg),
        .cfg        (cfg_reg),
        .distance   (dist_calc)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        echo_width_next  = echo_width_reg;
        dist_next        = dist_reg;
        upd              = 1'b0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (phase_ticks_reg >= cfg_reg.repeat_ticks)
                begin
                    phase_next       = PH_TRIG;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
            PH_TRIG:
            begin
                // a zero length still gives one trigger tick
                if (ticks_inc >= {10'd0, cfg_reg.trigger_ticks})
                begin
                    phase_next       = PH_LISTEN;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
            PH_LISTEN:
            begin
                if (rise)
                begin
                    phase_next       = PH_HIGH;
                    echo_width_next  = 16'd1;
                    phase_ticks_next = '0;
                end
                else if (phase_ticks_reg >= {2'd0, cfg_reg.echo_timeout_ticks})
                begin
                    phase_next       = PH_WAIT;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
            PH_HIGH:
            begin
                if (fall)
                begin
                    dist_next        = dist_calc;
                    upd              = 1'b1;
                    phase_next       = PH_WAIT;
                    phase_ticks_next = '0;
                end
                else if (echo_width_reg >= cfg_reg.echo_timeout_ticks)
                begin
                    phase_next       = PH_WAIT;
                    phase_ticks_next = '0;
                end
                else
                begin
                    echo_width_next = echo_width_reg + 16'd1;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_ticks       <= RST_REPEAT;
            cfg_reg.trigger_ticks      <= RST_TRIGGER;
            cfg_reg.echo_timeout_ticks <= RST_TIMEOUT;
            cfg_reg.max_echo_ticks     <= RST_MAX_ECHO;
            cfg_reg.near_cm            <= RST_NEAR;
            cfg_reg.far_cm             <= RST_FAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REPEAT:   cfg_reg.repeat_ticks       <= cfg_data;
                CFG_TRIGGER:  cfg_reg.trigger_ticks      <= cfg_data[7:0];
                CFG_TIMEOUT:  cfg_reg.echo_timeout_ticks <= cfg_data[15:0];
                CFG_MAX_ECHO: cfg_reg.max_echo_ticks     <= cfg_data[14:0];
                CFG_NEAR:     cfg_reg.near_cm            <= cfg_data[DIST_W-1:0];
                CFG_FAR:      cfg_reg.far_cm             <= cfg_data[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            phase_ticks_reg <= '0;
            echo_width_reg  <= '0;
            echo_prev_reg   <= 1'b0;
            dist_reg        <= RST_DIST;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                phase_reg       <= phase_next;
                phase_ticks_reg <= phase_ticks_next;
                echo_width_reg  <= echo_width_next;
                echo_prev_reg   <= echo_level;
                dist_reg        <= dist_next;
                m_valid_reg     <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            m_tdata_reg <= {4'd0, (dist_next < cfg_reg.near_cm), upd, dist_next, trig};
        end
    end

    // trigger drive reported for a transaction taken in the trigger phase
    a_trig_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (phase_reg == PH_TRIG)) |=> m_tdata_reg[0])
        else $error("trigger not reported in trigger phase");

    // a stored distance always ends the measurement with a fresh idle count
    a_upd_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && upd) |=> ((phase_reg == PH_WAIT) && (phase_ticks_reg == 18'd0)))
        else $error("distance update without return to idle");

    // sequencer advances only on an input transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> ($stable(phase_reg) && $stable(phase_ticks_reg) && $stable(dist_reg)))
        else $error("state moved without input transaction");

endmodule

[tb/tb_ultrasonic_range_sequencer.sv]
`timescale 1ns / 1ps

module tb_ultrasonic_range_sequencer;
    import urs_pkg::*;

    localparam int unsigned SOUND_NUM = 34;
    localparam int unsigned SOUND_DEN = 2000;

    typedef struct packed {
        logic              trigger;
        logic [DIST_W-1:0] distance;
        logic              updated;
        logic              near;
    } range_out_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_REPEAT;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;

    ultrasonic_range_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // sequencer mirror
    cfg_t              seq_cfg;
    logic [1:0]        seq_phase;
    logic [17:0]       seq_ticks;
    logic [15:0]       seq_width;
    logic              seq_prev;
    logic [DIST_W-1:0] seq_hold;

    range_out_t  pending_ranges[$];
    int unsigned mismatch_count = 0;
    int unsigned ticks_sent     = 0;
    int unsigned burst_left     = 0;
    logic        tx_idle        = 1'b1;
    logic        rx_steady      = 1'b0;
    logic [15:0] rx_pattern     = 16'hFFFF;
    logic [5:0]  rx_count       = '0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("** ultrasonic_range_sequencer: FAILED **");
        $finish;
    end

    // receiver stalls follow a rotating random pattern, reloaded each time the 6-bit rx_count wraps to zero
    always @(negedge clk)
    begin
        rx_count <= rx_count + 6'd1;
        if (rx_count == '0)
            rx_pattern <= 16'($urandom()) | 16'h1;
        else
            rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        m_axis_tready <= rx_steady | rx_pattern[0];
    end

    function automatic range_out_t predict_tick(input logic lvl);
        range_out_t  r;
        logic        rise;
        logic        fall;
        int unsigned d;
        rise      = lvl && !seq_prev;
        fall      = !lvl && seq_prev;
        r.trigger = (seq_phase == PH_TRIG);
        r.updated = 1'b0;
        case (seq_phase)
            PH_WAIT:
            begin
                if (seq_ticks >= seq_cfg.repeat_ticks)
                begin
                    seq_phase = PH_TRIG;
                    seq_ticks = '0;
                end
                else
                    seq_ticks = seq_ticks + 18'd1;
            end
            PH_TRIG:
            begin
                seq_ticks = seq_ticks + 18'd1;
                // a zero length still gives one trigger tick
                if (seq_ticks >= {10'd0, seq_cfg.trigger_ticks})
                begin
                    seq_phase = PH_LISTEN;
                    seq_ticks = '0;
                end
            end
            PH_LISTEN:
            begin
                if (rise)
                begin
                    seq_phase = PH_HIGH;
                    seq_width = 16'd1;
                    seq_ticks = '0;
                end
                else if (seq_ticks >= {2'd0, seq_cfg.echo_timeout_ticks})
                begin
                    seq_phase = PH_WAIT;
                    seq_ticks = '0;
                end
                else
                    seq_ticks = seq_ticks + 18'd1;
            end
            default:
            begin
                if (fall)
                begin
                    if (seq_width >= {1'b0, seq_cfg.max_echo_ticks})
                        d = {23'd0, seq_cfg.far_cm};
                    else
                    begin
                        d = {16'd0, seq_width} * SOUND_NUM / SOUND_DEN;
                        if (d > DIST_MAX)
                            d = {23'd0, seq_cfg.far_cm};
                    end
                    seq_hold  = d[DIST_W-1:0];
                    r.updated = 1'b1;
                    seq_phase = PH_WAIT;
                    seq_ticks = '0;
                end
                else if (seq_width >= seq_cfg.echo_timeout_ticks)
                begin
                    seq_phase = PH_WAIT;
                    seq_ticks = '0;
                end
                else
                    seq_width = seq_width + 16'd1;
            end
        endcase
        seq_prev   = lvl;
        r.distance = seq_hold;
        r.near     = (seq_hold < seq_cfg.near_cm);
        return r;
    endfunction

    always @(posedge clk)
    begin
        range_out_t got;
        range_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[9:1], m_axis_tdata[10],
                   m_axis_tdata[11]};
            if (pending_ranges.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected transaction trig=%0d dist=%0d upd=%0d near=%0d",
                             $realtime, got.trigger, got.distance, got.updated,
                             got.near);
            end
            else
            begin
                want = pending_ranges.pop_front();
                if (got.trigger !== want.trigger || got.distance !== want.distance ||
                    got.updated !== want.updated || got.near !== want.near)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: exp trig=%0d dist=%0d upd=%0d near=%0d, ",
                                  "got trig=%0d dist=%0d upd=%0d near=%0d"},
                                 $realtime, want.trigger, want.distance, want.updated,
                                 want.near, got.trigger, got.distance, got.updated,
                                 got.near);
                end
            end
        end
    end

    task automatic send_echo(input logic lvl);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = tx_idle ? $urandom_range(0, 5) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, lvl};
        do @(posedge clk); while (!s_axis_tready);
        pending_ranges.push_back(predict_tick(lvl));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_REPEAT:   seq_cfg.repeat_ticks       = val;
            CFG_TRIGGER:  seq_cfg.trigger_ticks      = val[7:0];
            CFG_TIMEOUT:  seq_cfg.echo_timeout_ticks = val[15:0];
            CFG_MAX_ECHO: seq_cfg.max_echo_ticks     = val[14:0];
            CFG_NEAR:     seq_cfg.near_cm            = val[DIST_W-1:0];
            CFG_FAR:      seq_cfg.far_cm             = val[DIST_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int unsigned rep, input int unsigned trg,
                              input int unsigned tmo, input int unsigned maxe,
                              input int unsigned near, input int unsigned far);
        wait_drained();
        write_reg(CFG_REPEAT, rep[CFG_DATA_W-1:0]);
        write_reg(CFG_TRIGGER, trg[CFG_DATA_W-1:0]);
        write_reg(CFG_TIMEOUT, tmo[CFG_DATA_W-1:0]);
        write_reg(CFG_MAX_ECHO, maxe[CFG_DATA_W-1:0]);
        write_reg(CFG_NEAR, near[CFG_DATA_W-1:0]);
        write_reg(CFG_FAR, far[CFG_DATA_W-1:0]);
    endtask

    // low until listening, low for wait_len more ticks, then a high pulse and one low tick
    task automatic ping(input int unsigned wait_len, input int unsigned pulse_len);
        while (seq_phase != PH_LISTEN)
            send_echo(1'b0);
        repeat (wait_len) send_echo(1'b0);
        repeat (pulse_len) send_echo(1'b1);
        send_echo(1'b0);
    endtask

    task automatic test_reset_state();
        repeat (12) send_echo(1'($urandom_range(0, 1)));
    endtask

    task automatic test_register_extremes();
        set_config(262143, 255, 65535, 32767, 511, 511);
        repeat (10) send_echo(1'($urandom_range(0, 1)));
        // zero repeat, zero trigger length, zero timeout, zero max width
        set_config(0, 0, 0, 0, 0, 0);
        ping(0, 1);
        ping(0, 2);
        ping(1, 1);
    endtask

    task automatic test_trigger_lengths();
        set_config(5, 255, 20, 32767, 25, 400);
        ping(3, 59);
        set_config(0, 1, 20, 32767, 25, 400);
        ping(2, 60);
        ping(0, 1);
    endtask

    task automatic test_distances();
        set_config(2, 3, 2000, 32767, 10, 300);
        ping(4, 1);
        ping(0, 58);
        ping(5, 59);
        ping(1, 588);
        ping(2, 589);
        // echo already high when listening starts: only the later rising edge counts
        repeat (15) send_echo(1'b1);
        repeat (2) send_echo(1'b0);
        repeat (60) send_echo(1'b1);
        send_echo(1'b0);
    endtask

    task automatic test_far_and_timeout();
        set_config(1, 2, 50, 100, 2, 123);
        ping(3, 100);
        ping(3, 99);
        ping(60, 5);
        ping(0, 50);
        ping(0, 51);
        set_config(1, 2, 50, 50, 2, 123);
        ping(0, 50);
    endtask

    task automatic test_out_of_range();
        tx_idle   = 1'b0;
        rx_steady = 1'b1;
        set_config(0, 1, 65535, 32767, 511, 77);
        ping(0, 30059);
        ping(0, 30118);
        wait_drained();
        tx_idle   = 1'b1;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_ranging();
        int unsigned start;
        int unsigned tmo;
        int unsigned pick;
        for (int p = 0; p < 4; p++)
        begin
            tmo = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(10, 160);
            set_config($urandom_range(0, 8), $urandom_range(0, 4), tmo,
                       $urandom_range(0, 200), $urandom_range(0, 3), $urandom_range(0, 511));
            tx_idle   = (p != 1);
            rx_steady = (p == 2);
            start     = ticks_sent;
            while (ticks_sent - start < 225)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    ping($urandom_range(0, tmo + 4), $urandom_range(1, tmo + 4));
                else if (pick < 96)
                    repeat ($urandom_range(1, 20)) send_echo(1'($urandom_range(0, 1)));
                else
                    wait_drained();
            end
        end
        tx_idle   = 1'b1;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        seq_cfg   = '{RST_REPEAT, RST_TRIGGER, RST_TIMEOUT, RST_MAX_ECHO, RST_NEAR, RST_FAR};
        seq_phase = PH_WAIT;
        seq_ticks = '0;
        seq_width = '0;
        seq_prev  = 1'b0;
        seq_hold  = RST_DIST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_extremes();
        test_trigger_lengths();
        test_distances();
        test_far_and_timeout();
        test_out_of_range();
        test_random_ranging();

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_ranges.size() == 0)
            $display("** ultrasonic_range_sequencer: PASSED **");
        else
            $display("** ultrasonic_range_sequencer: FAILED **");
        $finish;
    end

endmodule
